[rtl/assert_macros.svh]
// Assertion macros used by the pf_cipher stage of the digraph encryptor.
// Depends on nothing; the using module supplies aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define PF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, including during reset.
`define PF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/pf_pkg.sv]
// Types, constants and helper functions of the digraph encryptor.
// Depends on nothing; every RTL module imports it.
package pf_pkg;

    localparam int SQ_DIM   = 5;
    localparam int LETTER_W = 5;
    localparam int ROW_W    = SQ_DIM * LETTER_W;
    localparam int CELLS    = SQ_DIM * SQ_DIM;
    localparam int POS_W    = 3;
    localparam int IDX_W    = 3;
    localparam int RULE_W   = 2;

    localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
    localparam logic [LETTER_W-1:0] CODE_X = 5'd23;

    localparam logic [RULE_W-1:0] RULE_ROW  = 2'd0;
    localparam logic [RULE_W-1:0] RULE_COL  = 2'd1;
    localparam logic [RULE_W-1:0] RULE_RECT = 2'd2;

    localparam logic [IDX_W-1:0] REG_KEY_ROW_0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_ROW_1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_KEY_ROW_2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEY_ROW_3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_KEY_ROW_4 = 3'd4;

    localparam logic [POS_W-1:0] POS_LAST = 3'd4;

    typedef logic [SQ_DIM-1:0][ROW_W-1:0] pf_square_t;

    typedef struct packed {
        logic [LETTER_W-1:0] first_letter;
        logic [LETTER_W-1:0] second_letter;
        logic                second_present;
    } pf_in_t;

    typedef struct packed {
        logic [LETTER_W-1:0] cipher_first;
        logic [LETTER_W-1:0] cipher_second;
        logic [RULE_W-1:0]   rule_used;
        logic                letter_missing;
    } pf_out_t;

    typedef struct packed {
        logic [CELLS-1:0] hit_a;
        logic [CELLS-1:0] hit_b;
    } pf_match_t;

    typedef struct packed {
        logic [POS_W-1:0] row_a;
        logic [POS_W-1:0] col_a;
        logic [POS_W-1:0] row_b;
        logic [POS_W-1:0] col_b;
        logic             found_a;
        logic             found_b;
    } pf_pos_t;

    function automatic logic [POS_W-1:0] pf_wrap_inc(input logic [POS_W-1:0] p);
        return (p == POS_LAST) ? '0 : p + 3'd1;
    endfunction

    function automatic logic [LETTER_W-1:0] pf_cell(input pf_square_t sq,
                                                   input logic [POS_W-1:0] r,
                                                   input logic [POS_W-1:0] c);
        logic [ROW_W-1:0] row;
        row = sq[r];
        return row[LETTER_W*c +: LETTER_W];
    endfunction

endpackage

[rtl/pf_match.sv]
// First pipeline stage: normalizes both letters and compares each against all
// 25 key square cells. Depends on pf_pkg.
module pf_match
    import pf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pf_square_t square,
    input  logic       valid_i,
    output logic       ready_o,
    input  pf_in_t     data_i,
    output logic       valid_o,
    input  logic       ready_i,
    output pf_match_t  data_o
);

    logic                valid_reg;
    pf_match_t           data_reg;
    pf_match_t           data_next;
    logic [LETTER_W-1:0] letter_a;
    logic [LETTER_W-1:0] letter_b;

    always_comb begin
        letter_a = (data_i.first_letter == CODE_J) ? CODE_I : data_i.first_letter;
        letter_b = data_i.second_present ? data_i.second_letter : CODE_X;
        if (letter_b == CODE_J) begin
            letter_b = CODE_I;
        end
        data_next = '0;
        for (int r = 0; r < SQ_DIM; r++) begin
            for (int c = 0; c < SQ_DIM; c++) begin
                data_next.hit_a[r*SQ_DIM+c] = (square[r][LETTER_W*c +: LETTER_W] == letter_a);
                data_next.hit_b[r*SQ_DIM+c] = (square[r][LETTER_W*c +: LETTER_W] == letter_b);
            end
        end
    end

    assign ready_o = !valid_reg || ready_i;
    assign valid_o = valid_reg;
    assign data_o  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/pf_position.sv]
// Second pipeline stage: turns each match vector into the row and column of
// the first hit in row-major order. Depends on pf_pkg.
module pf_position
    import pf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      valid_i,
    output logic      ready_o,
    input  pf_match_t data_i,
    output logic      valid_o,
    input  logic      ready_i,
    output pf_pos_t   data_o
);

    logic    valid_reg;
    pf_pos_t data_reg;
    pf_pos_t data_next;

    always_comb begin
        data_next         = '0;
        data_next.found_a = |data_i.hit_a;
        data_next.found_b = |data_i.hit_b;
        for (int r = SQ_DIM - 1; r >= 0; r--) begin
            for (int c = SQ_DIM - 1; c >= 0; c--) begin
                if (data_i.hit_a[r*SQ_DIM+c]) begin
                    data_next.row_a = POS_W'(r);
                    data_next.col_a = POS_W'(c);
                end
                if (data_i.hit_b[r*SQ_DIM+c]) begin
                    data_next.row_b = POS_W'(r);
                    data_next.col_b = POS_W'(c);
                end
            end
        end
    end

    assign ready_o = !valid_reg || ready_i;
    assign valid_o = valid_reg;
    assign data_o  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/pf_cipher.sv]
// Third pipeline stage and output register: picks the rule and reads both
// cipher letters from the key square. Depends on pf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pf_cipher
    import pf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pf_square_t square,
    input  logic       valid_i,
    output logic       ready_o,
    input  pf_pos_t    data_i,
    output logic       valid_o,
    input  logic       ready_i,
    output pf_out_t    data_o
);

    logic    valid_reg;
    pf_out_t data_reg;
    pf_out_t data_next;

    always_comb begin
        data_next = '0;
        if (!(data_i.found_a && data_i.found_b)) begin
            data_next.letter_missing = 1'b1;
        end else if (data_i.row_a == data_i.row_b) begin
            data_next.cipher_first  = pf_cell(square, data_i.row_a, pf_wrap_inc(data_i.col_a));
            data_next.cipher_second = pf_cell(square, data_i.row_b, pf_wrap_inc(data_i.col_b));
            data_next.rule_used     = RULE_ROW;
        end else if (data_i.col_a == data_i.col_b) begin
            data_next.cipher_first  = pf_cell(square, pf_wrap_inc(data_i.row_a), data_i.col_a);
            data_next.cipher_second = pf_cell(square, pf_wrap_inc(data_i.row_b), data_i.col_b);
            data_next.rule_used     = RULE_COL;
        end else begin
            data_next.cipher_first  = pf_cell(square, data_i.row_a, data_i.col_b);
            data_next.cipher_second = pf_cell(square, data_i.row_b, data_i.col_a);
            data_next.rule_used     = RULE_RECT;
        end
    end

    assign ready_o = !valid_reg || ready_i;
    assign valid_o = valid_reg;
    assign data_o  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            data_reg <= data_next;
        end
    end

    `PF_ASSERT_ALWAYS(a_reset_clears_valid, !aresetn |=> !valid_reg, "output valid set after reset")
    `PF_ASSERT(a_stall_keeps_beat, valid_reg && !ready_i |=> valid_reg, "stalled beat dropped")
    `PF_ASSERT(a_missing_zeroes, valid_reg && data_reg.letter_missing |-> data_reg.cipher_first == '0 && data_reg.cipher_second == '0 && data_reg.rule_used == RULE_ROW, "missing letter with nonzero fields")

endmodule

[rtl/playfair_digraph_encrypt.sv]
// Throughput: one digraph per cycle while m_ready stays high, through three
// register stages (match, position, cipher select); a stall holds every full
// stage in place. Reset: synchronous, active low; clears all stage valid
// bits and the five key square rows to zero. The user must write key rows
// only while the block is idle; the block itself does not enforce this.
module playfair_digraph_encrypt
    import pf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  pf_in_t           s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output pf_out_t          m_payload
);

    pf_square_t key_row_reg;
    pf_square_t key_row_next;

    logic      match_valid;
    logic      match_ready;
    pf_match_t match_data;
    logic      pos_valid;
    logic      pos_ready;
    pf_pos_t   pos_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        key_row_next = key_row_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEY_ROW_0: key_row_next[0] = cfg_data;
                REG_KEY_ROW_1: key_row_next[1] = cfg_data;
                REG_KEY_ROW_2: key_row_next[2] = cfg_data;
                REG_KEY_ROW_3: key_row_next[3] = cfg_data;
                REG_KEY_ROW_4: key_row_next[4] = cfg_data;
                default: key_row_next = key_row_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_row_reg <= '0;
        end else begin
            key_row_reg <= key_row_next;
        end
    end

    pf_match u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .square  (key_row_reg),
        .valid_i (s_valid),
        .ready_o (s_ready),
        .data_i  (s_payload),
        .valid_o (match_valid),
        .ready_i (match_ready),
        .data_o  (match_data)
    );

    pf_position u_position (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid_i (match_valid),
        .ready_o (match_ready),
        .data_i  (match_data),
        .valid_o (pos_valid),
        .ready_i (pos_ready),
        .data_o  (pos_data)
    );

    pf_cipher u_cipher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .square  (key_row_reg),
        .valid_i (pos_valid),
        .ready_o (pos_ready),
        .data_i  (pos_data),
        .valid_o (m_valid),
        .ready_i (m_ready),
        .data_o  (m_payload)
    );

endmodule

[bench/playfair_digraph_encrypt_test.sv]
// Self-checking testbench for the Playfair digraph encryptor.
// Depends on pf_pkg and playfair_digraph_encrypt; predicts every result beat and
// checks it while both channels idle and stall at random.
`timescale 1ns / 1ps

module playfair_digraph_encrypt_test;
    import pf_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 64;
    localparam int HOLD_AT        = 40;
    localparam int PHASE_ITEMS    = 180;
    localparam int RESET_ROWS     = 6;

    localparam logic [LETTER_W-1:0] LTR_A             = 5'd0;
    localparam logic [LETTER_W-1:0] LTR_Z             = 5'd25;
    localparam logic [LETTER_W-1:0] CODE_FIRST_UNUSED = 5'd26;
    localparam logic [LETTER_W-1:0] CODE_TOP          = 5'd31;

    localparam pf_out_t NOT_IN_SQUARE = '{cipher_first: '0, cipher_second: '0,
                                          rule_used: RULE_ROW, letter_missing: 1'b1};

    typedef enum {KEY_SHUFFLED, KEY_NOISE, KEY_ALL_ONES, KEY_CLEARED} key_kind_e;
    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct {
        key_kind_e  key;
        idle_mode_e idle;
        bit         long_hold;
    } phase_t;

    typedef struct {
        pf_in_t  pair;
        bit      typed;
        pf_out_t cipher;
    } digraph_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0] cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    pf_in_t           s_payload = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    pf_out_t          m_payload;

    pf_square_t key_square = '0;
    pf_out_t    pending_ciphers[$];
    bit         typed_next = 1'b0;
    pf_out_t    typed_cipher = '0;
    int         fail_count = 0;
    int         quiet_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_reqs = 0;
    int         holds_served = 0;
    int         hold_left = 0;

    phase_t random_phases [8] = '{
        '{KEY_SHUFFLED, IDLE_NONE, 1'b0},
        '{KEY_SHUFFLED, IDLE_SEND, 1'b0},
        '{KEY_SHUFFLED, IDLE_RECV, 1'b1},
        '{KEY_NOISE,    IDLE_BOTH, 1'b0},
        '{KEY_ALL_ONES, IDLE_NONE, 1'b1},
        '{KEY_SHUFFLED, IDLE_BOTH, 1'b0},
        '{KEY_CLEARED,  IDLE_RECV, 1'b0},
        '{KEY_NOISE,    IDLE_SEND, 1'b0}
    };

    playfair_digraph_encrypt dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic logic [LETTER_W-1:0] letter_at(int r, int c);
        return key_square[r][LETTER_W*c +: LETTER_W];
    endfunction

    function automatic bit find_letter(input logic [LETTER_W-1:0] letter,
                                       output int row, output int col);
        logic [LETTER_W-1:0] key;
        bit hit;
        key = (letter == CODE_J) ? CODE_I : letter;
        hit = 1'b0;
        row = 0;
        col = 0;
        for (int r = 0; r < SQ_DIM; r++) begin
            for (int c = 0; c < SQ_DIM; c++) begin
                if (!hit && letter_at(r, c) == key) begin
                    hit = 1'b1;
                    row = r;
                    col = c;
                end
            end
        end
        return hit;
    endfunction

    function automatic pf_out_t encipher_digraph(pf_in_t d);
        logic [LETTER_W-1:0] a, b;
        int ra, ca, rb, cb;
        bit fa, fb;
        pf_out_t res;
        a = d.first_letter;
        b = d.second_present ? d.second_letter : CODE_X;
        fa = find_letter(a, ra, ca);
        fb = find_letter(b, rb, cb);
        res = NOT_IN_SQUARE;
        if (fa && fb) begin
            res.letter_missing = 1'b0;
            if (ra == rb) begin
                res.cipher_first  = letter_at(ra, (ca + 1) % SQ_DIM);
                res.cipher_second = letter_at(rb, (cb + 1) % SQ_DIM);
                res.rule_used     = RULE_ROW;
            end else if (ca == cb) begin
                res.cipher_first  = letter_at((ra + 1) % SQ_DIM, ca);
                res.cipher_second = letter_at((rb + 1) % SQ_DIM, cb);
                res.rule_used     = RULE_COL;
            end else begin
                res.cipher_first  = letter_at(ra, cb);
                res.cipher_second = letter_at(rb, ca);
                res.rule_used     = RULE_RECT;
            end
        end
        return res;
    endfunction

    function automatic logic [LETTER_W-1:0] ltr(byte ch);
        return LETTER_W'(ch - "A");
    endfunction

    function automatic pf_in_t digraph(logic [LETTER_W-1:0] a, logic [LETTER_W-1:0] b,
                                       logic present);
        pf_in_t d;
        d.first_letter   = a;
        d.second_letter  = b;
        d.second_present = present;
        return d;
    endfunction

    // Most letters are drawn from the square so that all three rules are reached.
    function automatic logic [LETTER_W-1:0] plausible_letter();
        logic [LETTER_W-1:0] l;
        if ($urandom_range(99) < 80) begin
            l = letter_at($urandom_range(SQ_DIM - 1), $urandom_range(SQ_DIM - 1));
            if (l == CODE_I && $urandom_range(1) == 1)
                l = CODE_J;
        end else begin
            l = LETTER_W'($urandom_range(CODE_TOP));
        end
        return l;
    endfunction

    function automatic pf_in_t random_digraph();
        return digraph(plausible_letter(), plausible_letter(), $urandom_range(9) != 0);
    endfunction

    function automatic pf_square_t square_from_text(string t);
        pf_square_t sq;
        for (int r = 0; r < SQ_DIM; r++)
            for (int c = 0; c < SQ_DIM; c++)
                sq[r][LETTER_W*c +: LETTER_W] = ltr(t[SQ_DIM*r + c]);
        return sq;
    endfunction

    function automatic pf_square_t build_square(key_kind_e kind);
        pf_square_t sq;
        logic [LETTER_W-1:0] deck [CELLS];
        logic [LETTER_W-1:0] tmp;
        int n, j;
        sq = '0;
        case (kind)
            KEY_SHUFFLED: begin
                n = 0;
                for (int l = 0; l <= LTR_Z; l++) begin
                    if (l != CODE_J) begin
                        deck[n] = LETTER_W'(l);
                        n++;
                    end
                end
                for (int i = CELLS - 1; i > 0; i--) begin
                    j = $urandom_range(i);
                    tmp = deck[i];
                    deck[i] = deck[j];
                    deck[j] = tmp;
                end
                for (int i = 0; i < CELLS; i++)
                    sq[i / SQ_DIM][LETTER_W*(i % SQ_DIM) +: LETTER_W] = deck[i];
            end
            KEY_NOISE: begin
                for (int r = 0; r < SQ_DIM; r++)
                    sq[r] = ROW_W'($urandom());
            end
            KEY_ALL_ONES: sq = '1;
            default: sq = '0;
        endcase
        return sq;
    endfunction

    task automatic write_key_reg(logic [IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Writes to the unused indexes go first and must leave the square untouched.
    task automatic program_square(pf_square_t sq);
        for (int k = 1; k <= 3; k++)
            write_key_reg(IDX_W'(REG_KEY_ROW_4 + k), ROW_W'($urandom()));
        for (int r = 0; r < SQ_DIM; r++)
            write_key_reg(IDX_W'(REG_KEY_ROW_0 + r), sq[r]);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_digraph(pf_in_t d, bit typed, pf_out_t cipher);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_payload    <= d;
        typed_next   <= typed;
        typed_cipher <= cipher;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_ciphers.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_idle(idle_mode_e mode);
        case (mode)
            IDLE_SEND: begin
                send_idle_pct  = 51;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 51;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 37;
                recv_stall_pct = 37;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    always @(negedge aclk) begin
        if (hold_reqs != holds_served) begin
            holds_served = hold_reqs;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        pf_out_t want;
        bit moved;
        if (!aresetn) begin
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                if (cfg_index <= REG_KEY_ROW_4)
                    key_square[cfg_index] = cfg_data;
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                pending_ciphers.push_back(typed_next ? typed_cipher : encipher_digraph(s_payload));
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (pending_ciphers.size() == 0) begin
                    $error("result beat with no digraph outstanding");
                    fail_count++;
                end else begin
                    want = pending_ciphers.pop_front();
                    if (m_payload.cipher_first !== want.cipher_first) begin
                        $error("cipher_first: expected %0d, got %0d",
                               want.cipher_first, m_payload.cipher_first);
                        fail_count++;
                    end
                    if (m_payload.cipher_second !== want.cipher_second) begin
                        $error("cipher_second: expected %0d, got %0d",
                               want.cipher_second, m_payload.cipher_second);
                        fail_count++;
                    end
                    if (m_payload.rule_used !== want.rule_used) begin
                        $error("rule_used: expected %0d, got %0d",
                               want.rule_used, m_payload.rule_used);
                        fail_count++;
                    end
                    if (m_payload.letter_missing !== want.letter_missing) begin
                        $error("letter_missing: expected %0d, got %0d",
                               want.letter_missing, m_payload.letter_missing);
                        fail_count++;
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        digraph_row_t directed_rows[$];

        // With the square cleared every cell holds A, so only A can be found.
        directed_rows.push_back('{digraph(LTR_A, LTR_A, 1'b1), 1'b1,
                                  '{LTR_A, LTR_A, RULE_ROW, 1'b0}});
        directed_rows.push_back('{digraph(LTR_A, LTR_Z, 1'b1), 1'b1, NOT_IN_SQUARE});
        directed_rows.push_back('{digraph(LTR_Z, LTR_A, 1'b1), 1'b1, NOT_IN_SQUARE});
        directed_rows.push_back('{digraph(LTR_A, CODE_TOP, 1'b0), 1'b1, NOT_IN_SQUARE});
        directed_rows.push_back('{digraph(CODE_TOP, CODE_TOP, 1'b1), 1'b1, NOT_IN_SQUARE});
        directed_rows.push_back('{digraph(CODE_J, LTR_A, 1'b1), 1'b1, NOT_IN_SQUARE});
        directed_rows.push_back('{digraph(ltr("P"), ltr("L"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("F"), ltr("P"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("M"), ltr("I"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("P"), ltr("I"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("T"), ltr("P"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("K"), ltr("T"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("H"), ltr("I"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("Z"), ltr("A"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("W"), ltr("Z"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("J"), ltr("R"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("E"), ltr("E"), 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("H"), CODE_TOP, 1'b0), 1'b0, '0});
        directed_rows.push_back('{digraph(ltr("X"), LTR_A, 1'b0), 1'b0, '0});
        directed_rows.push_back('{digraph(CODE_FIRST_UNUSED, LTR_A, 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(LTR_A, CODE_TOP, 1'b1), 1'b0, '0});
        directed_rows.push_back('{digraph(LTR_Z, LTR_A, 1'b1), 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < directed_rows.size(); i++) begin
            if (i == RESET_ROWS) begin
                s_valid <= 1'b0;
                wait_drained();
                program_square(square_from_text("PLAYFIREXMBCDGHKNOQSTUVWZ"));
            end
            send_digraph(directed_rows[i].pair, directed_rows[i].typed,
                         directed_rows[i].cipher);
        end

        foreach (random_phases[p]) begin
            s_valid <= 1'b0;
            wait_drained();
            program_square(build_square(random_phases[p].key));
            set_idle(random_phases[p].idle);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (random_phases[p].long_hold && n == HOLD_AT)
                    hold_reqs++;
                send_digraph(random_digraph(), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[playfair_digraph_encrypt.f]
+incdir+rtl
rtl/pf_pkg.sv
rtl/pf_match.sv
rtl/pf_position.sv
rtl/pf_cipher.sv
rtl/playfair_digraph_encrypt.sv
bench/playfair_digraph_encrypt_test.sv
